// ----- rtl/hbs_pkg.sv -----
// ----------------------------------------------------------------------------
// hbs_pkg: shared types and constants of the bump slope map block
// Field widths, register codes and the word formats passed between stages.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam int BYTE_W       = 8;
  localparam int HEIGHT_W     = 8;
  localparam int COL_W        = 11;
  localparam int ROW_W        = 12;
  localparam int SLOPE_W      = 8;
  localparam int TOL_W        = 8;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 3;

  localparam int WIDTH_RESET  = 2048;
  localparam int HEIGHT_RESET = 4096;

  localparam int SLOPE_BIAS   = 127;
  localparam int HEIGHT_MAX   = 255;

  // mean of three bytes: (sum * RECIP3) >> RECIP3_SHIFT, exact for sums up to 766
  localparam int DIV3         = 3;
  localparam int RECIP3_SHIFT = 11;
  localparam int RECIP3       = (2 ** RECIP3_SHIFT + DIV3 - 1) / DIV3;
  localparam int SUM_W        = 10;
  localparam int RECIP3_W     = 10;
  localparam int PROD_W       = SUM_W + RECIP3_W;

  localparam int NUM_RES      = 3;
  localparam int RES_IDX_W    = 2;

  typedef logic [HEIGHT_W-1:0] height_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_TOL,
    CFG_FROM_ALPHA,
    CFG_GREY,
    CFG_INVERT
  } cfg_idx_e;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic from_alpha;
    logic grey;
    logic invert;
  } height_cfg_t;

  // one pending result before slope arithmetic
  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    height_t          center;
    height_t          left;
    height_t          right;
    height_t          above;
    height_t          below;
  } res_raw_t;

  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic [SLOPE_W-1:0] horizontal_slope;
    logic [SLOPE_W-1:0] vertical_slope;
    logic               last_of_run;
  } slope_word_t;

endpackage

// ----- rtl/hbs_if.sv -----
// ----------------------------------------------------------------------------
// hbs_if: stream channels of the bump slope map block
// Pixel input channel and slope result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hbs_pixel_if;
  import hbs_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;
  logic [BYTE_W-1:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

interface hbs_slope_if;
  import hbs_pkg::*;

  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   column;
  logic [ROW_W-1:0]   row;
  logic [SLOPE_W-1:0] horizontal_slope;
  logic [SLOPE_W-1:0] vertical_slope;
  logic               last_of_run;

  modport source (output valid, output column, output row, output horizontal_slope,
                  output vertical_slope, output last_of_run, input ready);
  modport sink   (input valid, input column, input row, input horizontal_slope,
                  input vertical_slope, input last_of_run, output ready);
endinterface

// ----- rtl/hbs_height.sv -----
// ----------------------------------------------------------------------------
// hbs_height: pixel to height conversion
// Alpha, red, or rounded mean of R, G, B; optional inversion.
// ----------------------------------------------------------------------------
module hbs_height (
  input  hbs_pkg::pixel_t      pix_i,
  input  hbs_pkg::height_cfg_t cfg_i,
  output hbs_pkg::height_t     height_o
);
  import hbs_pkg::*;

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  height_t           mean;
  height_t           raw;

  // (r + g + b + 1) / 3 by reciprocal multiply
  assign sum  = SUM_W'(pix_i.red) + SUM_W'(pix_i.green) + SUM_W'(pix_i.blue) + SUM_W'(1);
  assign prod = PROD_W'(sum) * PROD_W'(RECIP3);
  assign mean = prod[RECIP3_SHIFT +: HEIGHT_W];

  always_comb begin
    if (cfg_i.from_alpha) begin
      raw = pix_i.alpha;
    end else if (cfg_i.grey) begin
      raw = pix_i.red;
    end else begin
      raw = mean;
    end
  end

  assign height_o = cfg_i.invert ? (HEIGHT_W'(HEIGHT_MAX) - raw) : raw;

endmodule

// ----- rtl/hbs_slope.sv -----
// ----------------------------------------------------------------------------
// hbs_slope: slope arithmetic for one result
// Outlier limiting against the centre, central differences, bias.
// ----------------------------------------------------------------------------
module hbs_slope (
  input  hbs_pkg::res_raw_t                res_i,
  input  logic [hbs_pkg::TOL_W-1:0]        tol_i,
  output logic [hbs_pkg::SLOPE_W-1:0]      hslope_o,
  output logic [hbs_pkg::SLOPE_W-1:0]      vslope_o
);
  import hbs_pkg::*;

  // neighbor farther than tol from centre falls back to centre; tol 0 = off
  function automatic height_t limit(height_t n, height_t c, logic [TOL_W-1:0] tol);
    logic [HEIGHT_W:0] d;
    if (n >= c) begin
      d = {1'b0, n} - {1'b0, c};
    end else begin
      d = {1'b0, c} - {1'b0, n};
    end
    return ((tol != '0) && (d > {1'b0, tol})) ? c : n;
  endfunction

  // bias + (p - m) / 2, halving truncated toward zero
  function automatic logic [SLOPE_W-1:0] half_diff(height_t p, height_t m);
    logic signed [HEIGHT_W+1:0] diff;
    logic signed [HEIGHT_W+1:0] half;
    logic signed [HEIGHT_W+1:0] total;
    diff  = $signed({2'b00, p}) - $signed({2'b00, m});
    half  = (diff + $signed({{(HEIGHT_W+1){1'b0}}, diff[HEIGHT_W+1]})) >>> 1;
    total = half + $signed((HEIGHT_W+2)'(SLOPE_BIAS));
    return total[SLOPE_W-1:0];
  endfunction

  height_t l_lim, r_lim, a_lim, b_lim;

  assign l_lim = limit(res_i.left,  res_i.center, tol_i);
  assign r_lim = limit(res_i.right, res_i.center, tol_i);
  assign a_lim = limit(res_i.above, res_i.center, tol_i);
  assign b_lim = limit(res_i.below, res_i.center, tol_i);

  assign hslope_o = half_diff(l_lim, r_lim);
  assign vslope_o = half_diff(b_lim, a_lim);

endmodule

// ----- rtl/hbs_line_store.sv -----
// ----------------------------------------------------------------------------
// hbs_line_store: the two previous rows of heights
// Upper row read at x and x+1, older row at x; read data registered,
// with bypass of the write made at the same edge as the read.
// ----------------------------------------------------------------------------
module hbs_line_store #(
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  hbs_pkg::height_t         wr_upper_i,
  input  hbs_pkg::height_t         wr_older_i,
  output hbs_pkg::height_t         upper_o,
  output hbs_pkg::height_t         upper_next_o,
  output hbs_pkg::height_t         older_o
);
  import hbs_pkg::*;

  localparam int AW = $clog2(DEPTH);

  height_t upper_mem [DEPTH];
  height_t older_mem [DEPTH];

  logic [AW-1:0] rd_addr_next;
  height_t       upper_q, upper_next_q, older_q;
  logic [AW-1:0] addr_q, addr_next_q;

  // most recent write, for the read that coincides with it
  logic          lastw_vld_q;
  logic [AW-1:0] lastw_addr_q;
  height_t       lastw_upper_q, lastw_older_q;

  assign rd_addr_next = rd_addr_i + AW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i] <= wr_upper_i;
      older_mem[wr_addr_i] <= wr_older_i;
    end
    if (rd_en_i) begin
      upper_q      <= upper_mem[rd_addr_i];
      upper_next_q <= upper_mem[rd_addr_next];
      older_q      <= older_mem[rd_addr_i];
      addr_q       <= rd_addr_i;
      addr_next_q  <= rd_addr_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lastw_vld_q <= 1'b0;
    end else if (wr_en_i) begin
      lastw_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      lastw_addr_q  <= wr_addr_i;
      lastw_upper_q <= wr_upper_i;
      lastw_older_q <= wr_older_i;
    end
  end

  assign upper_o      = (lastw_vld_q && (addr_q == lastw_addr_q)) ? lastw_upper_q : upper_q;
  assign upper_next_o = (lastw_vld_q && (addr_next_q == lastw_addr_q)) ?
                        lastw_upper_q : upper_next_q;
  assign older_o      = (lastw_vld_q && (addr_q == lastw_addr_q)) ? lastw_older_q : older_q;

endmodule

// ----- rtl/height_to_bump_slope_map.sv -----
// ----------------------------------------------------------------------------
// height_to_bump_slope_map: streaming height map to bump slope map
// Central-difference slopes over a cross of neighbors held in two line stores.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i   - RGBA pixels in raster order, one word per handshake.
//   slope_o - result words (column, row, two biased slopes, last_of_run).
//   cfg_*   - register writes (width, height, tolerance, height source flags),
//             made by the user only while the block holds no work; unenforced.
//   Pixel (x,y) emits pixel (x,y-1); on the last row it also emits (x-1,y),
//   and the last pixel of the image emits itself. last_of_run marks the final
//   word caused by one pixel.
//   Pipeline: input register (line store read, height), result buffer of up
//   to three words, output register. The first word of a pixel passes the
//   input register and the result buffer before the output register.
//   Throughput: with slope_o.ready high, one pixel per cycle on all rows but
//   the last; the output register moves one word per cycle, so last-row pixels
//   (up to two words) and the final pixel (up to three) hold the input longer.
//   Stall: a held slope_o.ready fills the output register, then the result
//   buffer, then the input register; pix_i.ready drops only then.
//   Reset: counters, neighbor window and registers to defaults (2048 x 4096,
//   tolerance off, mean of RGB, no inversion). Line stores are not cleared;
//   rows are always written before they are read.
// ----------------------------------------------------------------------------
module height_to_bump_slope_map #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  hbs_pixel_if.sink                        pix_i,
  hbs_slope_if.source                      slope_o,
  input  logic                             cfg_we_i,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hbs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import hbs_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam logic [CW-1:0] W_LAST_RST =
    CW'((WIDTH_RESET > MAX_WIDTH ? MAX_WIDTH : WIDTH_RESET) - 1);
  localparam logic [RW-1:0] H_LAST_RST =
    RW'((HEIGHT_RESET > MAX_HEIGHT ? MAX_HEIGHT : HEIGHT_RESET) - 1);

  // ---------------------------------------------------------------- config
  // Sizes stored as last index, already clamped to 1..MAX.
  logic [CW-1:0]    width_last_q, width_last_d;
  logic [RW-1:0]    height_last_q, height_last_d;
  logic [TOL_W-1:0] tol_q;
  height_cfg_t      hcfg_q;
  logic [31:0]      wd_cfg, hd_cfg;

  always_comb begin
    wd_cfg = 32'(cfg_wdata_i[WIDTH_REG_W-1:0]);
    hd_cfg = 32'(cfg_wdata_i[HEIGHT_REG_W-1:0]);
    if (wd_cfg == 32'd0) begin
      width_last_d = '0;
    end else if (wd_cfg > 32'(MAX_WIDTH)) begin
      width_last_d = CW'(MAX_WIDTH - 1);
    end else begin
      width_last_d = CW'(wd_cfg - 32'd1);
    end
    if (hd_cfg == 32'd0) begin
      height_last_d = '0;
    end else if (hd_cfg > 32'(MAX_HEIGHT)) begin
      height_last_d = RW'(MAX_HEIGHT - 1);
    end else begin
      height_last_d = RW'(hd_cfg - 32'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_last_q  <= W_LAST_RST;
      height_last_q <= H_LAST_RST;
      tol_q         <= '0;
      hcfg_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:      width_last_q      <= width_last_d;
        CFG_HEIGHT:     height_last_q     <= height_last_d;
        CFG_TOL:        tol_q             <= cfg_wdata_i[TOL_W-1:0];
        CFG_FROM_ALPHA: hcfg_q.from_alpha <= cfg_wdata_i[0];
        CFG_GREY:       hcfg_q.grey       <= cfg_wdata_i[0];
        CFG_INVERT:     hcfg_q.invert     <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // ------------------------------------------------------------- handshake
  logic in_acc;     // pixel taken into stage A
  logic a_adv;      // stage A pixel moves into the result buffer
  logic b_free;     // result buffer empty after this cycle
  logic out_load;   // a buffered word moves into the output register

  // --------------------------------------------------- raster position
  // Counters give the position of the next arriving pixel.
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          in_lcol, in_lrow;

  assign in_lcol = (col_q >= width_last_q);
  assign in_lrow = (row_q >= height_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (in_lcol) begin
        col_q <= '0;
        row_q <= in_lrow ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // --------------------------------------------------------------- stage A
  logic          a_vld_q;
  pixel_t        a_pix_q;
  logic [CW-1:0] a_x_q;
  logic [RW-1:0] a_y_q;
  logic          a_lcol_q, a_lrow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (in_acc) begin
      a_vld_q <= 1'b1;
    end else if (a_adv) begin
      a_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_pix_q.red   <= pix_i.red;
      a_pix_q.green <= pix_i.green;
      a_pix_q.blue  <= pix_i.blue;
      a_pix_q.alpha <= pix_i.alpha;
      a_x_q         <= col_q;
      a_y_q         <= row_q;
      a_lcol_q      <= in_lcol;
      a_lrow_q      <= in_lrow;
    end
  end

  // line stores: read as the pixel is taken, written as it leaves stage A
  height_t upper_x, upper_nx, older_x;
  height_t hv, cx;

  hbs_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (in_acc),
    .rd_addr_i    (col_q),
    .wr_en_i      (a_adv),
    .wr_addr_i    (a_x_q),
    .wr_upper_i   (hv),
    .wr_older_i   (cx),
    .upper_o      (upper_x),
    .upper_next_o (upper_nx),
    .older_o      (older_x)
  );

  hbs_height u_height (
    .pix_i    (a_pix_q),
    .cfg_i    (hcfg_q),
    .height_o (hv)
  );

  // Neighbor window: height one row up at x-1, current row at x-1 and x-2.
  height_t win_ul_q, win_l_q, win_l2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_ul_q <= '0;
      win_l_q  <= '0;
      win_l2_q <= '0;
    end else if (a_adv) begin
      win_ul_q <= cx;
      win_l2_q <= win_l_q;
      win_l_q  <= hv;
    end
  end

  logic               x_ge1, x_ge2, y_ge1, y_ge2;
  res_raw_t           res_new [NUM_RES];
  logic [NUM_RES-1:0] res_vld;

  assign x_ge1 = (a_x_q != '0);
  assign x_ge2 = (32'(a_x_q) >= 32'd2);
  assign y_ge1 = (a_y_q != '0);
  assign y_ge2 = (32'(a_y_q) >= 32'd2);
  assign cx    = y_ge1 ? upper_x : '0;

  // Up to three results per pixel, in emission order.
  always_comb begin
    // pixel directly above the arriving one
    res_new[0].column = COL_W'(a_x_q);
    res_new[0].row    = ROW_W'(a_y_q - RW'(1));
    res_new[0].center = cx;
    res_new[0].left   = x_ge1 ? win_ul_q : cx;
    res_new[0].right  = a_lcol_q ? cx : upper_nx;
    res_new[0].above  = y_ge2 ? older_x : cx;
    res_new[0].below  = hv;
    // last row: the pixel to the left, now that its right neighbor is known
    res_new[1].column = COL_W'(a_x_q - CW'(1));
    res_new[1].row    = ROW_W'(a_y_q);
    res_new[1].center = win_l_q;
    res_new[1].left   = x_ge2 ? win_l2_q : win_l_q;
    res_new[1].right  = hv;
    res_new[1].above  = y_ge1 ? win_ul_q : win_l_q;
    res_new[1].below  = win_l_q;
    // final pixel of the image flushes itself
    res_new[2].column = COL_W'(a_x_q);
    res_new[2].row    = ROW_W'(a_y_q);
    res_new[2].center = hv;
    res_new[2].left   = x_ge1 ? win_l_q : hv;
    res_new[2].right  = hv;
    res_new[2].above  = y_ge1 ? cx : hv;
    res_new[2].below  = hv;

    res_vld = {a_lrow_q && a_lcol_q, a_lrow_q && x_ge1, y_ge1};
  end

  // --------------------------------------------------------- result buffer
  logic [NUM_RES-1:0]   b_pend_q, b_after;
  res_raw_t             b_res_q [NUM_RES];
  logic [RES_IDX_W-1:0] sel_idx;
  logic [NUM_RES-1:0]   sel_mask;
  res_raw_t             b_sel;
  logic                 sel_last;

  // lowest pending index first, which is emission order
  always_comb begin
    if (b_pend_q[0]) begin
      sel_idx = RES_IDX_W'(0);
    end else if (b_pend_q[1]) begin
      sel_idx = RES_IDX_W'(1);
    end else begin
      sel_idx = RES_IDX_W'(2);
    end
  end

  assign sel_mask = NUM_RES'(1) << sel_idx;
  assign b_sel    = b_res_q[sel_idx];
  assign sel_last = ((b_pend_q & ~sel_mask) == '0);

  assign out_load = (b_pend_q != '0) && (!slope_o.valid || slope_o.ready);
  assign b_after  = out_load ? (b_pend_q & ~sel_mask) : b_pend_q;
  assign b_free   = (b_after == '0);
  assign a_adv    = a_vld_q && b_free;
  assign in_acc   = pix_i.valid && pix_i.ready;

  assign pix_i.ready = !a_vld_q || b_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_pend_q <= '0;
    end else if (a_adv) begin
      b_pend_q <= res_vld;
    end else begin
      b_pend_q <= b_after;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_res_q <= res_new;
    end
  end

  // ------------------------------------------------------- output register
  logic [SLOPE_W-1:0] hslope, vslope;
  logic               out_vld_q;
  slope_word_t        out_q;

  hbs_slope u_slope (
    .res_i    (b_sel),
    .tol_i    (tol_q),
    .hslope_o (hslope),
    .vslope_o (vslope)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (slope_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.column           <= b_sel.column;
      out_q.row              <= b_sel.row;
      out_q.horizontal_slope <= hslope;
      out_q.vertical_slope   <= vslope;
      out_q.last_of_run      <= sel_last;
    end
  end

  assign slope_o.valid            = out_vld_q;
  assign slope_o.column           = out_q.column;
  assign slope_o.row              = out_q.row;
  assign slope_o.horizontal_slope = out_q.horizontal_slope;
  assign slope_o.vertical_slope   = out_q.vertical_slope;
  assign slope_o.last_of_run      = out_q.last_of_run;

  // ------------------------------------------------------------ assertions
  // rest of a pixel's run follows without a gap
  ap_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slope_o.valid && slope_o.ready && !slope_o.last_of_run |=> slope_o.valid)
    else $error("result run broken before last_of_run");

  // a stalled output must not lose buffered words
  ap_buffer_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slope_o.valid && !slope_o.ready && (b_pend_q != '0) |=> b_pend_q == $past(b_pend_q))
    else $error("result buffer changed while output stalled");

  // every taken pixel lands in stage A
  ap_pixel_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> a_vld_q)
    else $error("accepted pixel missing from input register");

endmodule

// ----- tb/height_to_bump_slope_map_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// height_to_bump_slope_map_tb: self-checking bench for the bump slope map
// Streams RGBA pixels through the block under random bursts and output
// stalls. A cycle-free predictor tracks line stores, neighbor window and
// counters, queues the slope words each pixel should cause and matches every
// output word against them field by field. Configuration changes between
// frames and inside frames while the block is idle; the width never grows inside a frame.
// ----------------------------------------------------------------------------
module height_to_bump_slope_map_tb;
  import hbs_pkg::*;

  localparam int MAX_W          = 2048;
  localparam int MAX_H          = 4096;
  localparam int SETTLE_CYCLES  = 8;     // first word passes stage A and the result buffer before it shows up
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either channel
  localparam int EXTREME_PIXELS = 48;
  localparam int RANDOM_PIXELS  = 300;

  // --------------------------------------------------------------------------
  // Slope predictor: mirrors the block state and queues the expected words.
  // --------------------------------------------------------------------------
  class bump_slope_tracker;
    height_t     upper_row [MAX_W];
    height_t     older_row [MAX_W];
    height_t     above_left;    // previous row at x-1
    height_t     cur_left;      // current row at x-1
    height_t     cur_left2;     // current row at x-2
    int unsigned col_cnt;
    int unsigned row_cnt;

    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned tol_reg;
    bit          from_alpha;
    bit          grey;
    bit          invert;

    slope_word_t pending_slopes [$];
    int unsigned mismatches;

    function new();
      above_left = '0;
      cur_left   = '0;
      cur_left2  = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      tol_reg    = 0;
      from_alpha = 1'b0;
      grey       = 1'b0;
      invert     = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, int unsigned val);
      case (idx)
        CFG_WIDTH:      width_reg  = val & 'hFFF;
        CFG_HEIGHT:     height_reg = val & 'h1FFF;
        CFG_TOL:        tol_reg    = val & 'hFF;
        CFG_FROM_ALPHA: from_alpha = val[0];
        CFG_GREY:       grey       = val[0];
        CFG_INVERT:     invert     = val[0];
        default: ;
      endcase
    endfunction

    // zero reads as one, oversize saturates
    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_H) return MAX_H;
      return height_reg;
    endfunction

    function bit at_frame_start();
      return (col_cnt == 0) && (row_cnt == 0);
    endfunction

    function int pending();
      return pending_slopes.size();
    endfunction

    // outlier neighbors fall back to the center
    function int clip_to_center(int n, int c);
      int d;
      d = n - c;
      if (d < 0) d = -d;
      if (tol_reg != 0 && d > int'(tol_reg)) return c;
      return n;
    endfunction

    function slope_word_t make_word(int unsigned x, int unsigned y, int c, int l, int r,
                                    int a, int b);
      slope_word_t w;
      int dh, dv;
      dh = clip_to_center(l, c) - clip_to_center(r, c);
      dv = clip_to_center(b, c) - clip_to_center(a, c);
      w.column           = x[COL_W-1:0];
      w.row              = y[ROW_W-1:0];
      w.horizontal_slope = SLOPE_W'(SLOPE_BIAS + dh / 2);   // SV int divide truncates toward zero
      w.vertical_slope   = SLOPE_W'(SLOPE_BIAS + dv / 2);
      w.last_of_run      = 1'b0;
      return w;
    endfunction

    function void take_pixel(pixel_t p);
      slope_word_t words [NUM_RES];
      int unsigned w, h, x, y;
      int          hv, cx, lft, rgt, abv, n;
      bit          last_col, last_row;
      w = eff_width();
      h = eff_height();
      x = col_cnt;
      y = row_cnt;
      if (x >= MAX_W) x = MAX_W - 1;
      last_col = (x >= w - 1);
      last_row = (y >= h - 1);

      if (from_alpha)  hv = int'(p.alpha);
      else if (grey)   hv = int'(p.red);
      else             hv = (int'(p.red) + int'(p.green) + int'(p.blue) + 1) / DIV3;
      if (invert) hv = HEIGHT_MAX - hv;

      n  = 0;
      cx = 0;
      // center of the row above, completed by this pixel below it
      if (y >= 1) begin
        cx  = int'(upper_row[x]);
        lft = (x > 0) ? int'(above_left) : cx;
        rgt = last_col ? cx : int'(upper_row[x+1]);
        abv = (y >= 2) ? int'(older_row[x]) : cx;
        words[n] = make_word(x, y - 1, cx, lft, rgt, abv, hv);
        n++;
      end
      // last row: left neighbor of this pixel has no row below, emit it now
      if (last_row && x >= 1) begin
        lft = (x >= 2) ? int'(cur_left2) : int'(cur_left);
        abv = (y >= 1) ? int'(above_left) : int'(cur_left);
        words[n] = make_word(x - 1, y, int'(cur_left), lft, hv, abv, int'(cur_left));
        n++;
      end
      // final pixel of the frame flushes itself
      if (last_row && last_col) begin
        lft = (x >= 1) ? int'(cur_left) : hv;
        abv = (y >= 1) ? cx : hv;
        words[n] = make_word(x, y, hv, lft, hv, abv, hv);
        n++;
      end
      if (n > 0) words[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) pending_slopes.push_back(words[i]);

      older_row[x] = HEIGHT_W'(cx);
      upper_row[x] = HEIGHT_W'(hv);
      above_left   = HEIGHT_W'(cx);
      cur_left2    = cur_left;
      cur_left     = HEIGHT_W'(hv);
      if (last_col) begin
        col_cnt = 0;
        row_cnt = last_row ? 0 : y + 1;
      end else begin
        col_cnt = x + 1;
      end
    endfunction

    function void cmp_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void match_slope(slope_word_t got);
      slope_word_t exp_w;
      if (pending_slopes.size() == 0) begin
        $error("slope word with nothing pending: column %0d row %0d", got.column, got.row);
        mismatches++;
        return;
      end
      exp_w = pending_slopes.pop_front();
      cmp_field("column",           16'(exp_w.column),           16'(got.column));
      cmp_field("row",              16'(exp_w.row),              16'(got.row));
      cmp_field("horizontal_slope", 16'(exp_w.horizontal_slope), 16'(got.horizontal_slope));
      cmp_field("vertical_slope",   16'(exp_w.vertical_slope),   16'(got.vertical_slope));
      cmp_field("last_of_run",      16'(exp_w.last_of_run),      16'(got.last_of_run));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and channels
  // --------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  hbs_pixel_if pix_if ();
  hbs_slope_if slope_if ();

  height_to_bump_slope_map #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_if),
    .slope_o     (slope_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  bump_slope_tracker tracker = new();

  // traffic shaping knobs, changed per phase
  int unsigned rcv_mode;     // 0 never stalls, 1 light, 2 heavy
  int unsigned gap_mode;     // 0 back-to-back, 1 short gaps, 2 long gaps
  int unsigned burst_left;
  int unsigned random_sent;
  pixel_t      drift_px;     // base of the smooth pixel style

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Monitor: every word on either channel goes through the tracker
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    slope_word_t got;
    pixel_t      px;
    if (rst_ni) begin
      if (slope_if.valid && slope_if.ready) begin
        got.column           = slope_if.column;
        got.row              = slope_if.row;
        got.horizontal_slope = slope_if.horizontal_slope;
        got.vertical_slope   = slope_if.vertical_slope;
        got.last_of_run      = slope_if.last_of_run;
        tracker.match_slope(got);
      end
      if (pix_if.valid && pix_if.ready) begin
        px.red   = pix_if.red;
        px.green = pix_if.green;
        px.blue  = pix_if.blue;
        px.alpha = pix_if.alpha;
        tracker.take_pixel(px);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a long stretch with nothing moving means a hang
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((pix_if.valid && pix_if.ready) || (slope_if.valid && slope_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: ready follows alternating high/low stretches per mode
  // --------------------------------------------------------------------------
  initial begin : slope_receiver
    int unsigned hold;
    bit          level;
    hold  = 0;
    level = 1'b0;
    slope_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold == 0) begin
        case (rcv_mode)
          0: begin
            level = 1'b1;
            hold  = 16;
          end
          1: begin
            level = !level;
            hold  = level ? $urandom_range(4, 24) : $urandom_range(1, 3);
          end
          default: begin
            level = !level;
            hold  = level ? $urandom_range(1, 5) : $urandom_range(1, 30);
          end
        endcase
      end
      hold = hold - 1;
      slope_if.ready <= level;
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  // one pixel word; valid stays high between words of a burst
  task automatic send_pixel(input pixel_t px);
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if (gap_mode != 0) begin
        pix_if.valid <= 1'b0;
        repeat ($urandom_range(1, (gap_mode == 1) ? 3 : 9)) @(negedge clk_i);
      end
    end
    burst_left--;
    pix_if.valid <= 1'b1;
    pix_if.red   <= px.red;
    pix_if.green <= px.green;
    pix_if.blue  <= px.blue;
    pix_if.alpha <= px.alpha;
    do @(posedge clk_i); while (!pix_if.ready);
  endtask

  task automatic send_rgba(input logic [7:0] r, g, b, a);
    pixel_t px;
    px.red   = r;
    px.green = g;
    px.blue  = b;
    px.alpha = a;
    send_pixel(px);
  endtask

  // hold off the sender until every queued word has come out and the
  // pipeline has settled (row-0 pixels leave nothing queued)
  task automatic drain_block();
    @(negedge clk_i);
    pix_if.valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    tracker.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input int unsigned w, h, tol, input bit alpha_src, grey_src, inv);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_TOL, tol);
    write_reg(CFG_FROM_ALPHA, 32'(alpha_src));
    write_reg(CFG_GREY, 32'(grey_src));
    write_reg(CFG_INVERT, 32'(inv));
  endtask

  // 0: uniform bytes, 1: bytes at 0 or 255, 2: smooth drift with rare spikes
  function automatic pixel_t make_pixel(input int unsigned style);
    logic [3:0][7:0] bytes_v;
    logic [3:0][7:0] base_v;
    logic [7:0]      d;
    base_v = drift_px;
    for (int i = 0; i < 4; i++) begin
      case (style)
        0: bytes_v[i] = 8'($urandom_range(0, 255));
        1: bytes_v[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: begin
          d = 8'($urandom_range(0, 8));
          bytes_v[i] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                   : base_v[i] + d - 8'd4;
        end
      endcase
    end
    if (style >= 2) drift_px = bytes_v;
    return bytes_v;
  endfunction

  function automatic int unsigned pick_tolerance();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return 0;
      4:          return 255;
      5:          return $urandom_range(1, 8);
      default:    return $urandom_range(1, 254);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned n, style, w_val, cur_w;
    bit          at_start;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_WIDTH;
    cfg_wdata_i  = '0;
    pix_if.valid = 1'b0;
    pix_if.red   = '0;
    pix_if.green = '0;
    pix_if.blue  = '0;
    pix_if.alpha = '0;
    rcv_mode     = 0;
    gap_mode     = 0;
    burst_left   = 0;
    random_sent  = 0;
    drift_px     = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- directed: 4x3 frame, mean of RGB, all borders and rounding -------
    set_config(4, 3, 0, 1'b0, 1'b0, 1'b0);
    send_rgba(8'd0,   8'd0,   8'd0,   8'd0);
    send_rgba(8'd255, 8'd255, 8'd255, 8'd255);
    send_rgba(8'd1,   8'd1,   8'd0,   8'd0);     // sum 2 rounds up to 1
    send_rgba(8'd2,   8'd0,   8'd0,   8'd9);
    send_rgba(8'd255, 8'd0,   8'd0,   8'd0);
    send_rgba(8'd0,   8'd255, 8'd255, 8'd0);
    send_rgba(8'd254, 8'd255, 8'd255, 8'd128);
    send_rgba(8'd0,   8'd0,   8'd1,   8'd255);   // sum 1 rounds down to 0
    send_rgba(8'd255, 8'd255, 8'd254, 8'd3);
    send_rgba(8'd10,  8'd20,  8'd30,  8'd77);
    send_rgba(8'd0,   8'd0,   8'd0,   8'd255);
    send_rgba(8'd128, 8'd128, 8'd128, 8'd0);
    drain_block();

    // zero sizes behave as a 1x1 frame: every pixel flushes itself
    rcv_mode = 2;
    set_config(0, 0, 0, 1'b0, 1'b0, 1'b0);
    send_rgba(8'd255, 8'd255, 8'd255, 8'd0);
    send_rgba(8'd0,   8'd0,   8'd0,   8'd255);
    drain_block();

    // alpha height, inverted, tolerance 1 replaces every big step
    gap_mode = 1;
    set_config(2, 2, 1, 1'b1, 1'b0, 1'b1);
    send_rgba(8'd12,  8'd34,  8'd56,  8'd0);
    send_rgba(8'd0,   8'd0,   8'd0,   8'd255);
    send_rgba(8'd255, 8'd255, 8'd255, 8'd1);
    send_rgba(8'd7,   8'd7,   8'd7,   8'd200);
    drain_block();

    // grey source, single row: everything comes out on the last-row path
    set_config(3, 1, 0, 1'b0, 1'b1, 1'b0);
    send_rgba(8'd255, 8'd0,   8'd0,   8'd0);
    send_rgba(8'd0,   8'd255, 8'd255, 8'd255);
    send_rgba(8'd7,   8'd99,  8'd1,   8'd0);
    drain_block();

    // height shrunk mid-frame: the current row turns into the last one
    rcv_mode = 0;
    gap_mode = 0;
    set_config(2, 3, 0, 1'b0, 1'b0, 1'b0);
    send_rgba(8'd40,  8'd50,  8'd60,  8'd0);
    send_rgba(8'd200, 8'd10,  8'd90,  8'd0);
    send_rgba(8'd3,   8'd3,   8'd3,   8'd0);
    drain_block();
    write_reg(CFG_HEIGHT, 1);
    send_rgba(8'd250, 8'd251, 8'd252, 8'd0);
    drain_block();

    // --- oversize registers saturate; frames closed by shrinking the size -
    rcv_mode = 1;
    gap_mode = 1;
    set_config(4095, 1, pick_tolerance(), 1'b0, 1'b0, 1'b0);
    repeat (EXTREME_PIXELS) send_pixel(make_pixel($urandom_range(0, 2)));
    drain_block();
    write_reg(CFG_WIDTH, 1);
    send_pixel(make_pixel(0));
    drain_block();

    rcv_mode = 2;
    gap_mode = 0;
    set_config(1, 8191, pick_tolerance(), 1'b0, 1'b1, 1'b1);
    repeat (EXTREME_PIXELS) send_pixel(make_pixel($urandom_range(0, 2)));
    drain_block();
    write_reg(CFG_HEIGHT, 1);
    send_pixel(make_pixel(0));
    drain_block();

    // --- random phases: partial and full frames, shrinking mid-frame ------
    while (random_sent < RANDOM_PIXELS) begin
      rcv_mode = $urandom_range(0, 2);
      gap_mode = $urandom_range(0, 2);
      style    = $urandom_range(0, 2);
      at_start = tracker.at_frame_start();
      cur_w    = tracker.eff_width();

      if (at_start || $urandom_range(0, 1)) begin
        // widening is only safe at a frame boundary, the rows above must exist
        if (at_start) begin
          case ($urandom_range(0, 9))
            0:       w_val = 0;
            1, 2:    w_val = $urandom_range(9, 24);
            default: w_val = $urandom_range(1, 8);
          endcase
        end else begin
          w_val = $urandom_range(0, cur_w);
        end
        write_reg(CFG_WIDTH, w_val);
      end
      if ($urandom_range(0, 1))
        write_reg(CFG_HEIGHT, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12)
                                                           : $urandom_range(1, 6));
      if ($urandom_range(0, 1)) write_reg(CFG_TOL, pick_tolerance());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_FROM_ALPHA, $urandom_range(0, 1));
      if ($urandom_range(0, 1)) write_reg(CFG_GREY, $urandom_range(0, 1));
      if ($urandom_range(0, 1)) write_reg(CFG_INVERT, $urandom_range(0, 1));

      n = $urandom_range(1, tracker.eff_width() * (tracker.eff_height() + 1));
      if (n > RANDOM_PIXELS - random_sent) n = RANDOM_PIXELS - random_sent;
      repeat (n) send_pixel(make_pixel(style));
      random_sent += n;
      drain_block();
    end

    // --- wrap up ----------------------------------------------------------
    drain_block();
    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
